// ===== rtl/sdlu_pkg.sv =====
// ----------------------------------------------------------------------------
// sdlu_pkg: shared constants and types of the shuffled dual LCG source
// Moduli, multipliers, folding factors and the sequencer state type.
// ----------------------------------------------------------------------------
package sdlu_pkg;

    localparam int SAMPLE_W = 31;
    localparam int DEF_TABLE_DEPTH = 32;

    localparam logic [30:0] MOD1 = 31'd2147483563;
    localparam logic [30:0] MOD2 = 31'd2147483399;
    localparam logic [30:0] TOP1 = 31'd2147483562;
    localparam logic [15:0] MUL1 = 16'd40014;
    localparam logic [15:0] MUL2 = 16'd40692;

    // 2^31 reduced by each modulus, used to fold the high product bits.
    localparam logic [7:0] FOLD1 = 8'd85;
    localparam logic [7:0] FOLD2 = 8'd249;

    localparam logic [30:0] SEED2_RESET = 31'd123456789;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_MUL,
        ST_FOLD,
        ST_RED,
        ST_DIV,
        ST_READ,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_WARM,
        PH_GEN1,
        PH_GEN2
    } t_phase;

endpackage

// ===== rtl/shuffled_dual_lcg_uniform_core.sv =====
// ----------------------------------------------------------------------------
// shuffled_dual_lcg_uniform_core: combined LCG source with shuffle table
// Two multiplicative congruential generators share one multiply and fold
// unit; the first passes through a TABLE_DEPTH-entry table, less the second.
// ----------------------------------------------------------------------------
//  Channel   Signals                                  Direction
//  input     i_in_valid, o_in_stall, i_reseed         item in
//  output    o_out_valid, i_out_stall, o_sample       item out
//  config    i_cfg_we, i_cfg_wdata                    seed write
//
// A draw is registered at the output after two modular multiplications on the
// shared unit (multiply, fold, reduce each), the slot (reciprocal estimate, one
// correction), a table read and the write-back.
// A reseed adds a seed load and TABLE_DEPTH + 8 warm-up steps on the shared unit.
// Reset is synchronous; the first item after reset always reseeds.
// The input is stalled while an item is in work; a held result delays only
// the write-back of the next item.
module shuffled_dual_lcg_uniform_core #(
    parameter int TABLE_DEPTH = sdlu_pkg::DEF_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_reseed,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [30:0] o_sample,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata
);

    localparam int SW = $clog2(TABLE_DEPTH);
    localparam int WARMUP = TABLE_DEPTH + 8;
    localparam int CW = $clog2(WARMUP);
    localparam int RECIP_SHIFT = 40;
    localparam logic [30:0] SLOT_DIV = 31'(1 + 2147483562 / TABLE_DEPTH);
    localparam logic [15:0] SLOT_RECIP = 16'((64'd1 << RECIP_SHIFT) / {33'd0, SLOT_DIV});

    sdlu_pkg::t_state r_state, n_state;
    sdlu_pkg::t_phase r_phase;

    logic [30:0] r_seed;
    logic [30:0] r_gen1;
    logic [30:0] r_gen2;
    logic [30:0] r_last;
    logic        r_seeded;
    logic [CW-1:0] r_cnt;
    logic [46:0] r_prod;
    logic [31:0] r_fold;
    logic [SW-1:0] r_quot;
    logic        r_div_step;
    logic [30:0] r_rdata;
    logic        r_out_valid;
    logic [30:0] r_sample;

    logic [30:0] mem [TABLE_DEPTH];

    logic [30:0] op_x;
    logic [15:0] op_a;
    logic [7:0]  op_k;
    logic [30:0] op_m;
    logic [46:0] mul_out;
    logic [31:0] fold_out;
    logic [30:0] red_out;
    logic [30:0] seed_red;
    logic [30:0] seed_val;
    logic [46:0] est_prod;
    logic [SW:0] quot_inc;
    logic [SW+30:0] fix_prod;
    logic        fix_up;
    logic [SW-1:0] slot;
    logic [30:0] sample_val;
    logic        out_load;
    logic        mem_we;
    logic [SW-1:0] mem_waddr;
    logic [30:0] mem_wdata;
    logic        warm_wr;

    assign op_x = (r_phase == sdlu_pkg::PH_GEN2) ? r_gen2 : r_gen1;
    assign op_a = (r_phase == sdlu_pkg::PH_GEN2) ? sdlu_pkg::MUL2 : sdlu_pkg::MUL1;
    assign op_k = (r_phase == sdlu_pkg::PH_GEN2) ? sdlu_pkg::FOLD2 : sdlu_pkg::FOLD1;
    assign op_m = (r_phase == sdlu_pkg::PH_GEN2) ? sdlu_pkg::MOD2 : sdlu_pkg::MOD1;

    assign mul_out  = {16'd0, op_x} * {31'd0, op_a};
    assign fold_out = {1'b0, r_prod[30:0]} + ({16'd0, r_prod[46:31]} * {24'd0, op_k});
    assign red_out  = (r_fold >= {1'b0, op_m}) ? 31'(r_fold - {1'b0, op_m}) : r_fold[30:0];

    assign seed_red = (r_seed >= sdlu_pkg::MOD1) ? r_seed - sdlu_pkg::MOD1 : r_seed;
    assign seed_val = (seed_red == 31'd0) ? 31'd1 : seed_red;

    // The reciprocal estimate is the true slot or one below it.
    assign est_prod = {16'd0, r_last} * {31'd0, SLOT_RECIP};
    assign quot_inc = {1'b0, r_quot} + (SW + 1)'(1);
    assign fix_prod = {30'd0, quot_inc} * {{SW{1'b0}}, SLOT_DIV};
    assign fix_up   = ({{SW{1'b0}}, r_last} >= fix_prod);

    assign slot = ({1'b0, r_quot} >= (SW + 1)'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH - 1) : r_quot;

    assign sample_val = (r_rdata > r_gen2) ? r_rdata - r_gen2
                                           : 31'(({1'b0, r_rdata} + {1'b0, sdlu_pkg::TOP1})
                                                 - {1'b0, r_gen2});

    assign warm_wr = ({1'b0, r_cnt} < (CW + 1)'(TABLE_DEPTH));

    always_comb begin
        n_state   = r_state;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = slot;
        mem_wdata = r_gen1;
        unique case (r_state)
            sdlu_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_reseed || !r_seeded) ? sdlu_pkg::ST_SEED : sdlu_pkg::ST_MUL;
                end
            end
            sdlu_pkg::ST_SEED: begin
                n_state = sdlu_pkg::ST_MUL;
            end
            sdlu_pkg::ST_MUL: begin
                n_state = sdlu_pkg::ST_FOLD;
            end
            sdlu_pkg::ST_FOLD: begin
                n_state = sdlu_pkg::ST_RED;
            end
            sdlu_pkg::ST_RED: begin
                n_state = (r_phase == sdlu_pkg::PH_GEN2) ? sdlu_pkg::ST_DIV : sdlu_pkg::ST_MUL;
                if (r_phase == sdlu_pkg::PH_WARM && warm_wr) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cnt[SW-1:0];
                    mem_wdata = red_out;
                end
            end
            sdlu_pkg::ST_DIV: begin
                if (r_div_step) begin
                    n_state = sdlu_pkg::ST_READ;
                end
            end
            sdlu_pkg::ST_READ: begin
                n_state = sdlu_pkg::ST_OUT;
            end
            sdlu_pkg::ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    mem_we   = 1'b1;
                    n_state  = sdlu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sdlu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdlu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= 31'd1;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= sdlu_pkg::PH_GEN1;
            r_gen1      <= 31'd0;
            r_gen2      <= sdlu_pkg::SEED2_RESET;
            r_last      <= 31'd0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                sdlu_pkg::ST_IDLE: begin
                    r_phase <= sdlu_pkg::PH_GEN1;
                end
                sdlu_pkg::ST_SEED: begin
                    r_gen1  <= seed_val;
                    r_gen2  <= seed_val;
                    r_cnt   <= CW'(WARMUP - 1);
                    r_phase <= sdlu_pkg::PH_WARM;
                end
                sdlu_pkg::ST_MUL: begin
                    r_prod <= mul_out;
                end
                sdlu_pkg::ST_FOLD: begin
                    r_fold <= fold_out;
                end
                sdlu_pkg::ST_RED: begin
                    unique case (r_phase)
                        sdlu_pkg::PH_WARM: begin
                            r_gen1 <= red_out;
                            if (r_cnt == '0) begin
                                r_last   <= red_out;
                                r_seeded <= 1'b1;
                                r_phase  <= sdlu_pkg::PH_GEN1;
                            end else begin
                                r_cnt <= r_cnt - 1'b1;
                            end
                        end
                        sdlu_pkg::PH_GEN1: begin
                            r_gen1  <= red_out;
                            r_phase <= sdlu_pkg::PH_GEN2;
                        end
                        sdlu_pkg::PH_GEN2: begin
                            r_gen2     <= red_out;
                            r_div_step <= 1'b0;
                        end
                        default: begin
                            r_phase <= sdlu_pkg::PH_GEN1;
                        end
                    endcase
                end
                sdlu_pkg::ST_DIV: begin
                    if (!r_div_step) begin
                        r_quot     <= est_prod[RECIP_SHIFT +: SW];
                        r_div_step <= 1'b1;
                    end else if (fix_up) begin
                        r_quot <= r_quot + 1'b1;
                    end
                end
                sdlu_pkg::ST_READ: begin
                    r_phase <= sdlu_pkg::PH_GEN1;
                end
                sdlu_pkg::ST_OUT: begin
                    if (out_load) begin
                        r_last <= sample_val;
                    end
                end
                default: begin
                    r_phase <= sdlu_pkg::PH_GEN1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_sample <= sample_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[slot];
    end

    assign o_in_stall  = (r_state != sdlu_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

endmodule

// ===== rtl/sdlu_checker.sv =====
// ----------------------------------------------------------------------------
// sdlu_checker: port-level checks of the shuffled dual LCG source
// Watches the handshakes and the result range at the top level's ports.
// ----------------------------------------------------------------------------
module sdlu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [30:0] o_sample
);

    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample != 31'd0) && (o_sample <= sdlu_pkg::TOP1))
        else $error("Sample outside its range.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample)))
        else $error("Stalled output item changed.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input not stalled after an item was accepted.");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("Output item appeared without an item in work.");

endmodule

bind shuffled_dual_lcg_uniform_core sdlu_checker u_sdlu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_sample    (o_sample)
);

// ===== dv/sdlu_checker.sv =====
// ----------------------------------------------------------------------------
// sdlu_scoreboard: scoreboard for the shuffled dual LCG source
// Watches the seed writes and both item channels. It keeps its own copy of
// the two generators, the last sample and the shuffle table, predicts the
// sample of every accepted item, and compares each accepted result with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sdlu_scoreboard #(
    parameter int TABLE_DEPTH = sdlu_pkg::DEF_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_reseed,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [30:0] i_sample,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata,
    output int          o_pending,
    output int          o_fail_count
);

    localparam int WARM_STEPS = TABLE_DEPTH + 8;
    localparam logic [30:0] SLOT_SPAN = sdlu_pkg::TOP1 / TABLE_DEPTH + 31'd1;

    logic [30:0] seed_reg;
    logic [30:0] gen_a;
    logic [30:0] gen_b;
    logic [30:0] last_sample;
    logic [30:0] shuffle [TABLE_DEPTH];
    logic        seeded;
    logic [30:0] sample_q [$];
    int          fail_count = 0;

    function automatic logic [30:0] lcg_next(logic [30:0] x, logic [15:0] mul,
                                             logic [30:0] modulus);
        logic [63:0] prod;
        prod = 64'(x) * 64'(mul);
        return 31'(prod % 64'(modulus));
    endfunction

    function automatic void load_seed();
        logic [30:0] s;
        s = seed_reg;
        if (s >= sdlu_pkg::MOD1) begin
            s = s - sdlu_pkg::MOD1;
        end
        if (s == 31'd0) begin
            s = 31'd1;
        end
        gen_a = s;
        gen_b = s;
        for (int k = WARM_STEPS - 1; k >= 0; k--) begin
            gen_a = lcg_next(gen_a, sdlu_pkg::MUL1, sdlu_pkg::MOD1);
            if (k < TABLE_DEPTH) begin
                shuffle[k] = gen_a;
            end
        end
        last_sample = shuffle[0];
        seeded = 1'b1;
    endfunction

    function automatic logic [30:0] draw_sample(logic reseed);
        logic [30:0] slot;
        logic [30:0] held;
        if (reseed || !seeded) begin
            load_seed();
        end
        gen_a = lcg_next(gen_a, sdlu_pkg::MUL1, sdlu_pkg::MOD1);
        gen_b = lcg_next(gen_b, sdlu_pkg::MUL2, sdlu_pkg::MOD2);
        slot = last_sample / SLOT_SPAN;
        if (slot >= TABLE_DEPTH) begin
            slot = 31'(TABLE_DEPTH - 1);
        end
        held = shuffle[slot];
        // A difference below one wraps by the top value of the first modulus.
        if (held > gen_b) begin
            last_sample = held - gen_b;
        end else begin
            last_sample = sdlu_pkg::TOP1 - (gen_b - held);
        end
        shuffle[slot] = gen_a;
        return last_sample;
    endfunction

    always @(posedge i_clk) begin
        logic [30:0] want;
        if (!i_rst_n) begin
            seed_reg = 31'd1;
            gen_a = '0;
            gen_b = sdlu_pkg::SEED2_RESET;
            last_sample = '0;
            foreach (shuffle[k]) begin
                shuffle[k] = '0;
            end
            seeded = 1'b0;
            sample_q.delete();
        end else begin
            if (i_cfg_we) begin
                seed_reg = i_cfg_wdata;
            end
            if (i_out_valid && !i_out_stall) begin
                if (sample_q.size() == 0) begin
                    $error("sample %0d arrived with no item outstanding", i_sample);
                    fail_count++;
                end else begin
                    want = sample_q.pop_front();
                    if (i_sample !== want) begin
                        $error("sample mismatch: expected %0d, actual %0d", want, i_sample);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                sample_q.push_back(draw_sample(i_reseed));
            end
        end
        o_pending <= sample_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for shuffled_dual_lcg_uniform_core
// Drives seed writes and draw requests with random gaps and output stalls,
// including a long output hold that backs the block up. A directed opening
// covers the forced first reseed, the extreme seeds and explicit reseeds;
// random phases follow with fresh seeds. The scoreboard predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 630;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        reseed;
    logic        out_valid;
    logic        out_stall;
    logic [30:0] sample;
    logic        cfg_we;
    logic [30:0] cfg_wdata;
    int          pending;
    int          fail_count;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    always #5 clk = ~clk;

    shuffled_dual_lcg_uniform_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_reseed    (reseed),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_sample    (sample),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    sdlu_scoreboard u_scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_reseed     (reseed),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_sample     (sample),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [30:0] pick_seed();
        case ($urandom_range(0, 9))
            0: return 31'd0;
            1: return sdlu_pkg::TOP1;
            2: return sdlu_pkg::MOD1;
            3: return 31'h7FFF_FFFF;
            4: return sdlu_pkg::MOD1 + 31'($urandom_range(1, 200));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic want_reseed);
        int gap;
        in_valid <= 1'b1;
        reseed <= want_reseed;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        gap = 0;
        if (!quiet && $urandom_range(0, 1) == 0) begin
            gap = gap_length();
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            reseed <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_seed(input logic [30:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_wdata <= 31'($urandom);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    // Output side: random stall runs, quiet stretches, and one long hold.
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_req = 1'b0;
            end else if (quiet || $urandom_range(0, 3) != 0) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b1;
                repeat (gap_length() - 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL shuffled_dual_lcg_uniform_core");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int sent;
        int phase;
        int count;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        reseed <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first item reseeds from the reset seed even without the flag.
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        wait_drained();
        write_seed(31'd0);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        wait_drained();
        write_seed(sdlu_pkg::TOP1);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        wait_drained();
        write_seed(sdlu_pkg::MOD1);
        send_item(1'b1);
        send_item(1'b0);
        wait_drained();
        write_seed(31'h7FFF_FFFF);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        wait_drained();
        write_seed(31'h2AAA_AAAA);
        send_item(1'b1);
        send_item(1'b0);
        wait_drained();
        write_seed(31'h5555_5555);
        send_item(1'b0);
        send_item(1'b1);
        wait_drained();

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            write_seed(pick_seed());
            quiet = ($urandom_range(0, 4) == 0);
            count = $urandom_range(20, 60);
            if (phase == 2) begin
                // Hold the output long enough for the block to back up.
                quiet = 1'b1;
                hold_req = 1'b1;
                count = 12;
            end
            if (count > RANDOM_ITEMS - sent) begin
                count = RANDOM_ITEMS - sent;
            end
            for (int k = 0; k < count; k++) begin
                if (k == 0) begin
                    send_item($urandom_range(0, 3) != 0);
                end else begin
                    send_item($urandom_range(0, 15) == 0);
                end
            end
            sent += count;
            phase++;
            wait_drained();
            while (hold_req) begin
                @(posedge clk);
            end
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS shuffled_dual_lcg_uniform_core");
        end else begin
            $display("FAIL shuffled_dual_lcg_uniform_core");
        end
        $finish;
    end

endmodule
